FILE: sv/bsa_pkg.sv
// Package for the bitmap slot allocator: payload structs, state codes,
// status and operation codes, and default parameter values. No dependencies.
package bsa_pkg;

    localparam int SLOT_WORDS_DEF      = 32;
    localparam int FIRST_USER_WORD_DEF = 1;
    localparam int WORD_BITS           = 32;
    localparam int HANDLE_W            = 16;
    localparam int SLOT_HANDLE_W       = 12;
    localparam int STATUS_W            = 2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STS_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] STS_INVALID = 2'd2;

    typedef struct packed {
        logic                func;
        logic [HANDLE_W-1:0] handle;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [SLOT_HANDLE_W-1:0] slot_handle;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_RESP
    } t_state;

endpackage

FILE: sv/bitmap_slot_allocator.sv
// Top level of the bitmap slot allocator: request decode, word scan state
// machine and output register. Depends on bsa_pkg and bsa_bitmap_mem.
//
// Channel   Direction  Handshake                   Payload
// request   in         i_in_valid / o_in_ready     i_in_data  (bsa_pkg::t_req)
// response  out        o_out_valid / i_out_ready   o_out_data (bsa_pkg::t_rsp)
//
// One request is in work at a time. An allocate transaction reads one bitmap
// word per cycle from the memory's single read port, starting at
// FIRST_USER_WORD, and scans at most SLOT_WORDS-FIRST_USER_WORD words; it
// stalls on the word it stops on until the output register is free.
// Reset is synchronous and clears the bitmap at once through per-word flags,
// so no clearing pass is needed. While the output register holds a response
// that is not taken, the block still accepts a new request and works on it,
// and holds its finished response until the register frees.
module bitmap_slot_allocator #(
    parameter int SLOT_WORDS      = bsa_pkg::SLOT_WORDS_DEF,
    parameter int FIRST_USER_WORD = bsa_pkg::FIRST_USER_WORD_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bsa_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bsa_pkg::t_rsp o_out_data
);

    localparam int  WW         = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1;
    localparam int  FULL_HW    = WW + 7;
    localparam bit  USER_EMPTY = FIRST_USER_WORD >= SLOT_WORDS;
    localparam logic [WW-1:0] LAST_WORD  = WW'(SLOT_WORDS - 1);
    localparam logic [WW-1:0] FIRST_WORD = WW'(FIRST_USER_WORD);

    // Lowest clear bit of a word; only used when the word is not full.
    function automatic logic [4:0] first_zero(input logic [bsa_pkg::WORD_BITS-1:0] w);
        logic [4:0] pos;
        pos = '0;
        for (int i = bsa_pkg::WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                pos = 5'(i);
            end
        end
        return pos;
    endfunction

    bsa_pkg::t_state r_state, n_state;
    logic [WW-1:0]   r_addr, n_addr;
    logic [4:0]      r_bit, n_bit;
    logic [bsa_pkg::STATUS_W-1:0] r_imm, n_imm;

    logic            r_out_vld;
    bsa_pkg::t_rsp   r_out;

    logic [WW-1:0]                 rd_addr;
    logic [bsa_pkg::WORD_BITS-1:0] rd_data;
    logic                          mem_we;
    logic [bsa_pkg::WORD_BITS-1:0] mem_wdata;

    logic            out_free;
    logic            res_vld;
    bsa_pkg::t_rsp   res;

    logic [8:0]      h_word;
    logic            free_ok;
    logic [4:0]      zero_pos;
    logic [FULL_HW-1:0] alloc_handle;

    bsa_bitmap_mem #(
        .SLOT_WORDS (SLOT_WORDS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (mem_we),
        .i_wr_addr (r_addr),
        .i_wr_data (mem_wdata)
    );

    // A handle to free must be word aligned and fall inside the user words.
    // Its bits 15:7 are the bitmap word and bits 6:2 the bit within it.
    assign h_word  = i_in_data.handle[15:7];
    assign free_ok = (i_in_data.handle[1:0] == 2'b00)
                  && (h_word >= 9'(FIRST_USER_WORD))
                  && ({1'b0, h_word} < 10'(SLOT_WORDS));

    assign zero_pos     = first_zero(rd_data);
    assign alloc_handle = {r_addr, zero_pos, 2'b00};

    // The output register can take a new response this cycle.
    assign out_free = !r_out_vld || i_out_ready;

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_bit      = r_bit;
        n_imm      = r_imm;
        rd_addr    = r_addr;
        mem_we     = 1'b0;
        mem_wdata  = rd_data;
        res_vld    = 1'b0;
        res        = '0;
        o_in_ready = 1'b0;
        case (r_state)
            bsa_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_data.func == bsa_pkg::FUNC_ALLOC) begin
                        if (USER_EMPTY) begin
                            n_imm   = bsa_pkg::STS_NO_FREE;
                            n_state = bsa_pkg::S_RESP;
                        end else begin
                            rd_addr = FIRST_WORD;
                            n_addr  = FIRST_WORD;
                            n_state = bsa_pkg::S_SCAN;
                        end
                    end else begin
                        if (free_ok) begin
                            rd_addr = h_word[WW-1:0];
                            n_addr  = h_word[WW-1:0];
                            n_bit   = i_in_data.handle[6:2];
                            n_state = bsa_pkg::S_FREE;
                        end else begin
                            n_imm   = bsa_pkg::STS_INVALID;
                            n_state = bsa_pkg::S_RESP;
                        end
                    end
                end
            end
            bsa_pkg::S_SCAN: begin
                // The word at r_addr is on rd_data. A stall re-reads it.
                if (rd_data != '1) begin
                    if (out_free) begin
                        mem_we          = 1'b1;
                        mem_wdata       = rd_data | (32'b1 << zero_pos);
                        res_vld         = 1'b1;
                        res.status      = bsa_pkg::STS_OK;
                        res.slot_handle = bsa_pkg::SLOT_HANDLE_W'(alloc_handle);
                        n_state         = bsa_pkg::S_IDLE;
                    end
                end else if (r_addr == LAST_WORD) begin
                    if (out_free) begin
                        res_vld    = 1'b1;
                        res.status = bsa_pkg::STS_NO_FREE;
                        n_state    = bsa_pkg::S_IDLE;
                    end
                end else begin
                    rd_addr = r_addr + WW'(1);
                    n_addr  = r_addr + WW'(1);
                end
            end
            bsa_pkg::S_FREE: begin
                if (out_free) begin
                    res_vld = 1'b1;
                    n_state = bsa_pkg::S_IDLE;
                    if (rd_data[r_bit]) begin
                        mem_we     = 1'b1;
                        mem_wdata  = rd_data & ~(32'b1 << r_bit);
                        res.status = bsa_pkg::STS_OK;
                    end else begin
                        res.status = bsa_pkg::STS_INVALID;
                    end
                end
            end
            bsa_pkg::S_RESP: begin
                if (out_free) begin
                    res_vld    = 1'b1;
                    res.status = r_imm;
                    n_state    = bsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bsa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bsa_pkg::S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (res_vld) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_bit  <= n_bit;
        r_imm  <= n_imm;
        if (res_vld) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

FILE: sv/bsa_bitmap_mem.sv
// Bitmap word store of the slot allocator: a synchronous memory with one
// read and one write port, plus per-word written flags cleared at reset.
module bsa_bitmap_mem #(
    parameter int SLOT_WORDS = bsa_pkg::SLOT_WORDS_DEF,
    localparam int WW = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [WW-1:0]                  i_rd_addr,
    output logic [bsa_pkg::WORD_BITS-1:0]  o_rd_data,
    input  logic                           i_wr_en,
    input  logic [WW-1:0]                  i_wr_addr,
    input  logic [bsa_pkg::WORD_BITS-1:0]  i_wr_data
);

    logic [bsa_pkg::WORD_BITS-1:0] mem [SLOT_WORDS];
    logic [bsa_pkg::WORD_BITS-1:0] r_q;
    logic [SLOT_WORDS-1:0]         r_vld;
    logic                          r_q_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_q <= mem[i_rd_addr];
    end

    // A word that was never written since reset reads as all free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_q_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_q_vld ? r_q : '0;

endmodule

FILE: dv/bsa_checker.sv
// Scoreboard for the bitmap slot allocator: watches both channels, keeps its own
// occupancy map and compares every response field by field.
// Depends on bsa_pkg only.
module bsa_checker
    import bsa_pkg::*;
#(
    parameter int SLOT_WORDS      = SLOT_WORDS_DEF,
    parameter int FIRST_USER_WORD = FIRST_USER_WORD_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_req i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_rsp i_out_data,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_n_alloc_ok,
    output int   o_n_free_ok,
    output int   o_n_no_free,
    output int   o_n_invalid
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTES_PER_WORD = WORD_BITS * 4;

    logic [WORD_BITS-1:0] occ_map [SLOT_WORDS];
    t_rsp                 expected_rsp_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_n_alloc_ok = 0;
        o_n_free_ok  = 0;
        o_n_no_free  = 0;
        o_n_invalid  = 0;
    end

    // Lowest clear bit of the first user word that is not full.
    function automatic t_rsp grant_slot();
        t_rsp        r;
        int          w;
        int          b;
        int unsigned h;
        r.status      = STS_NO_FREE;
        r.slot_handle = '0;
        for (w = FIRST_USER_WORD; w < SLOT_WORDS; w++) begin
            if (occ_map[w] != '1) begin
                for (b = 0; b < WORD_BITS; b++) begin
                    if (!occ_map[w][b]) break;
                end
                occ_map[w][b] = 1'b1;
                h             = (w * WORD_BITS + b) * 4;
                r.status      = STS_OK;
                r.slot_handle = h[SLOT_HANDLE_W-1:0];
                return r;
            end
        end
        return r;
    endfunction

    function automatic t_rsp release_slot(logic [HANDLE_W-1:0] h);
        t_rsp        r;
        int unsigned lo;
        int unsigned hi;
        int unsigned slot;
        int unsigned w;
        r.status      = STS_INVALID;
        r.slot_handle = '0;
        lo            = FIRST_USER_WORD * BYTES_PER_WORD;
        hi            = SLOT_WORDS * BYTES_PER_WORD;
        slot          = 32'(h) >> 2;
        w             = slot / WORD_BITS;
        if (h[1:0] == 2'b00 && 32'(h) >= lo && 32'(h) < hi) begin
            if (occ_map[w][slot % WORD_BITS]) begin
                occ_map[w][slot % WORD_BITS] = 1'b0;
                r.status = STS_OK;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp predicted;
        t_rsp head;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_WORDS; i++) occ_map[i] = '0;
            expected_rsp_q.delete();
        end else begin
            // Requests first, so a same-edge response still finds its entry.
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.func == FUNC_ALLOC) begin
                    predicted = grant_slot();
                    if (predicted.status == STS_OK) o_n_alloc_ok++;
                    else o_n_no_free++;
                end else begin
                    predicted = release_slot(i_in_data.handle);
                    if (predicted.status == STS_OK) o_n_free_ok++;
                    else o_n_invalid++;
                end
                expected_rsp_q.push_back(predicted);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_rsp_q.size() == 0) begin
                    $display("%0t: unexpected response: status %0d handle 0x%03h",
                             $time, i_out_data.status, i_out_data.slot_handle);
                    o_fail_count++;
                end else begin
                    head = expected_rsp_q.pop_front();
                    if (i_out_data.status != head.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, head.status, i_out_data.status);
                        o_fail_count++;
                    end
                    if (i_out_data.slot_handle != head.slot_handle) begin
                        $display("%0t: slot_handle mismatch: expected 0x%03h, actual 0x%03h",
                                 $time, head.slot_handle, i_out_data.slot_handle);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_rsp_q.size();
    end

endmodule

FILE: dv/tb_bitmap_slot_allocator.sv
// Top of the bitmap slot allocator testbench: clock, reset, request and
// response drivers, traffic phases and the verdict.
// Depends on bsa_pkg, bitmap_slot_allocator and bsa_checker.
module tb_bitmap_slot_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import bsa_pkg::*;

    localparam int SLOT_WORDS      = SLOT_WORDS_DEF;
    localparam int FIRST_USER_WORD = FIRST_USER_WORD_DEF;
    localparam int BYTES_PER_WORD  = WORD_BITS * 4;
    // Drain time, sized to cover an allocate that walks every user word.
    localparam int DRAIN_CYCLES    = SLOT_WORDS + 16;
    // Long enough for the block to hold a finished response, take one more
    // request, and then push back on the request channel.
    localparam int HOLD_CYCLES     = 300;
    // Slowest legal quiet stretch is the hold-off above; leave a wide margin.
    localparam int WATCHDOG_LIMIT  = 4000;

    typedef enum logic [1:0] {
        GAP_NONE,
        GAP_SEND,
        GAP_RECV,
        GAP_BOTH
    } t_gap_mode;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_req i_in_data   = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_rsp o_out_data;

    int chk_fail_count;
    int chk_pending;
    int chk_n_alloc_ok;
    int chk_n_free_ok;
    int chk_n_no_free;
    int chk_n_invalid;

    t_gap_mode gap_mode = GAP_NONE;
    int        n_req_done = 0;
    int        n_rsp_done = 0;
    int        quiet_cycles = 0;
    int        hold_trigger = 0;
    int        hold_seen = 0;
    int        hold_left = 0;

    // Handles that the block has granted; frees are mostly drawn from here so
    // that they hit allocated slots instead of bouncing as invalid.
    logic [SLOT_HANDLE_W-1:0] live_handles [$];

    always #6 i_clk = ~i_clk;

    bitmap_slot_allocator #(
        .SLOT_WORDS      (SLOT_WORDS),
        .FIRST_USER_WORD (FIRST_USER_WORD)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    bsa_checker #(
        .SLOT_WORDS      (SLOT_WORDS),
        .FIRST_USER_WORD (FIRST_USER_WORD)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (chk_fail_count),
        .o_pending    (chk_pending),
        .o_n_alloc_ok (chk_n_alloc_ok),
        .o_n_free_ok  (chk_n_free_ok),
        .o_n_no_free  (chk_n_no_free),
        .o_n_invalid  (chk_n_invalid)
    );

    function automatic int send_gap_pct(t_gap_mode m);
        case (m)
            GAP_SEND: return 84;
            GAP_BOTH: return 6;
            default:  return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(t_gap_mode m);
        case (m)
            GAP_RECV: return 84;
            GAP_BOTH: return 6;
            default:  return 0;
        endcase
    endfunction

    // Transaction counters, the pool of granted handles and the watchdog all
    // sample the channels at the rising edge.
    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) n_req_done <= n_req_done + 1;
        if (o_out_valid && i_out_ready) begin
            n_rsp_done <= n_rsp_done + 1;
            // A free that succeeds also answers OK, but always with handle zero,
            // and zero is never a user handle, so this only collects grants.
            if (o_out_data.status == STS_OK && o_out_data.slot_handle != '0)
                live_handles.push_back(o_out_data.slot_handle);
        end
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, giving up", $time, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Response side. A bump of hold_trigger starts a long hold-off that this
    // process counts down on its own; otherwise ready follows the gap mode.
    always @(negedge i_clk) begin
        if (hold_seen != hold_trigger) begin
            hold_seen   <= hold_trigger;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct(gap_mode));
        end
    end

    // Called at a falling edge. Optionally idles first, then offers the request
    // and returns at the rising edge where it was accepted. Valid is left high
    // so a back-to-back request just swaps the payload at the next falling edge.
    task automatic push_request(t_req rq);
        while ($urandom_range(99) < send_gap_pct(gap_mode)) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = rq;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic issue(logic f, logic [HANDLE_W-1:0] h);
        @(negedge i_clk);
        push_request('{func: f, handle: h});
    endtask

    // Random request. Allocates carry a random (ignored) handle field. Frees
    // mostly target granted handles, then any aligned handle in the user
    // region, then handles near the region edges, then fully random values.
    function automatic t_req make_request(int alloc_pct);
        t_req        rq;
        logic [31:0] rnd;
        int          pick;
        int          idx;
        rnd       = $urandom;
        rq.handle = rnd[HANDLE_W-1:0];
        if ($urandom_range(99) < alloc_pct) begin
            rq.func = FUNC_ALLOC;
        end else begin
            rq.func = FUNC_FREE;
            pick    = $urandom_range(99);
            if (pick < 55 && live_handles.size() > 0) begin
                idx       = $urandom_range(live_handles.size() - 1);
                rq.handle = '0;
                rq.handle[SLOT_HANDLE_W-1:0] = live_handles[idx];
                live_handles.delete(idx);
            end else if (pick < 80) begin
                rnd = $urandom_range(SLOT_WORDS * WORD_BITS - 1,
                                     FIRST_USER_WORD * WORD_BITS) << 2;
                rq.handle = rnd[HANDLE_W-1:0];
            end else if (pick < 90) begin
                rnd = ((pick % 2) ? FIRST_USER_WORD * BYTES_PER_WORD
                                  : SLOT_WORDS * BYTES_PER_WORD)
                      + $urandom_range(16) - 8;
                rq.handle = rnd[HANDLE_W-1:0];
            end
        end
        return rq;
    endfunction

    // The mode only changes at a rising edge, so the response process never
    // sees it change at the falling edge where it reads it.
    task automatic run_phase(t_gap_mode m, int n_items, int alloc_pct);
        t_req rq;
        gap_mode = m;
        repeat (n_items) begin
            @(negedge i_clk);
            rq = make_request(alloc_pct);
            push_request(rq);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        // Directed opening on a freshly cleared table.
        issue(FUNC_ALLOC, 16'h0000);     // first user slot
        issue(FUNC_ALLOC, 16'h0000);     // next slot in the same word
        issue(FUNC_FREE,  16'd132);      // release it
        issue(FUNC_FREE,  16'd132);      // slot is no longer allocated
        issue(FUNC_FREE,  16'd130);      // not a multiple of four
        issue(FUNC_FREE,  16'h0000);     // below the user region
        issue(FUNC_FREE,  16'd124);      // last aligned handle below the user region
        issue(FUNC_FREE,  16'd127);      // misaligned, below the user region
        issue(FUNC_FREE,  16'(SLOT_WORDS * BYTES_PER_WORD));  // first handle past the table
        issue(FUNC_FREE,  16'hFFFF);     // all ones
        issue(FUNC_FREE,  16'hFFFC);     // aligned, far past the table
        issue(FUNC_FREE,  16'(SLOT_WORDS * BYTES_PER_WORD - 4));  // last slot, never granted
        issue(FUNC_ALLOC, 16'hFFFF);     // handle field must be ignored, reuses the freed slot
        issue(FUNC_FREE,  16'd128);      // free the lowest user slot
        issue(FUNC_ALLOC, 16'h5555);     // the lowest slot comes back
        issue(FUNC_FREE,  16'h8000);
        issue(FUNC_FREE,  16'hAAAA);
        issue(FUNC_FREE,  16'h5554);
        issue(FUNC_FREE,  16'd136);      // never granted, inside the first user word

        // Mixed traffic, then a long allocate-heavy run that fills the table
        // so that full-word skipping and the table-full answer get exercised.
        run_phase(GAP_NONE, 250, 60);
        run_phase(GAP_SEND, 250, 60);
        run_phase(GAP_RECV, 880, 100);
        run_phase(GAP_BOTH, 300, 45);

        // Back-pressure: the response side holds off while requests keep
        // coming, so the block fills up and stalls the request channel.
        hold_trigger++;
        run_phase(GAP_NONE, 60, 50);

        // Let every outstanding response come back before going on.
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (n_rsp_done == n_req_done);

        run_phase(GAP_NONE, 200, 55);

        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (n_rsp_done == n_req_done);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests: %0d slots granted, %0d table-full answers,",
                 n_req_done, chk_n_alloc_ok, chk_n_no_free);
        $display("%0d frees accepted and %0d rejected, under four idle mixes and a hold-off.",
                 chk_n_free_ok, chk_n_invalid);
        if (chk_pending != 0)
            $display("%0t: %0d expected responses never arrived", $time, chk_pending);
        if (chk_fail_count == 0 && chk_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/bsa_pkg.sv
sv/bsa_bitmap_mem.sv
sv/bitmap_slot_allocator.sv
dv/bsa_checker.sv
dv/tb_bitmap_slot_allocator.sv
